FILE: sv/cde_pkg.sv
// ----------------------------------------------------------------------------
// cde_pkg
// Shared constants, command and status types and the month-length lookup
// for the calendar date engine.
// ----------------------------------------------------------------------------
package cde_pkg;

	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned AMT_W    = 12;
	localparam int unsigned ACTION_W = 3;
	// day accumulator: largest day plus largest amount
	localparam int unsigned DSUM_W   = 13;

	localparam logic [ACTION_W-1:0] ACT_LOAD       = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_ADD_DAYS   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_ADD_MONTHS = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_ADD_YEARS  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_COMPARE    = 3'd4;

	localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
	localparam logic [YEAR_W-1:0]  YEAR_RESET  = 14'd1970;
	localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd1;
	localparam logic [DAY_W-1:0]   DAY_RESET   = 5'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;

	localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic apply;
		logic mul_load;
		logic mul_sel_month;
		logic fold;
		logic split;
		logic day_step;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                month_ok;
		logic                day_fits;
	} stat_t;

	function automatic logic month_in_range(input logic [MONTH_W-1:0] m);
		month_in_range = (m >= 4'd1) && (m <= MONTH_DEC);
	endfunction

	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [MONTH_W-1:0] idx;
		logic [DAY_W-1:0]   d;
		idx = month_in_range(m) ? (m - 4'd1) : 4'd0;
		d = MONTH_LEN[idx];
		if (m == MONTH_FEB && leap) begin
			d = d + 5'd1;
		end
		days_in = d;
	endfunction

endpackage

FILE: sv/cde_dp.sv
// ----------------------------------------------------------------------------
// cde_dp
// Datapath: held date, operand capture, shared constant multiplier for the
// divide-by-twelve and divide-by-hundred steps, month roll and result register.
// ----------------------------------------------------------------------------
module cde_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cde_pkg::cmd_t                        cmd,
	output cde_pkg::stat_t                       stat,
	input  logic [cde_pkg::ACTION_W-1:0]         action,
	input  logic [cde_pkg::YEAR_W-1:0]           in_year,
	input  logic [cde_pkg::MONTH_W-1:0]          in_month,
	input  logic [cde_pkg::DAY_W-1:0]            in_day,
	input  logic [cde_pkg::AMT_W-1:0]            amount,
	output logic [cde_pkg::YEAR_W-1:0]           cur_year,
	output logic [cde_pkg::MONTH_W-1:0]          cur_month,
	output logic [cde_pkg::DAY_W-1:0]            cur_day,
	output logic                                 date_valid,
	output logic                                 is_less,
	output logic                                 is_equal,
	output logic                                 is_greater,
	output logic                                 year_overflow
);

	// x/3 = (x * 683) >> 11 for x below 2048; y/25 = (y * 1311) >> 15 for y below 4681
	localparam logic [10:0] RECIP_3  = 11'd683;
	localparam logic [10:0] RECIP_25 = 11'd1311;

	logic [cde_pkg::ACTION_W-1:0] act_q;
	logic [cde_pkg::YEAR_W-1:0]   iy_q;
	logic [cde_pkg::MONTH_W-1:0]  im_q;
	logic [cde_pkg::DAY_W-1:0]    id_q;
	logic [cde_pkg::AMT_W-1:0]    amt_q;

	logic [cde_pkg::YEAR_W-1:0]   year_q;
	logic [cde_pkg::MONTH_W-1:0]  month_q;
	logic [cde_pkg::DAY_W-1:0]    day_q;

	logic [cde_pkg::DSUM_W-1:0]   dsum_q;
	logic [cde_pkg::DSUM_W-1:0]   msum_q;
	logic [22:0]                  prod_q;
	logic [6:0]                   cent_q;
	logic [6:0]                   yrem_q;

	logic ovf_q, lt_q, eq_q, gt_q;

	logic [cde_pkg::DSUM_W-1:0]   msum_m1;
	logic [11:0]                  mul_a;
	logic [10:0]                  mul_b;
	logic [8:0]                   fold_k;
	logic [cde_pkg::DSUM_W-1:0]   fold_12k;
	logic [cde_pkg::DSUM_W-1:0]   fold_month;
	logic [cde_pkg::YEAR_W:0]     year_sum;
	logic [cde_pkg::YEAR_W:0]     add_year_sum;
	logic [6:0]                   split_c;
	logic [cde_pkg::YEAR_W-1:0]   split_rem;
	logic                         leap;
	logic [cde_pkg::DAY_W-1:0]    mlen;
	logic                         fits;
	logic [22:0]                  held_key;
	logic [22:0]                  given_key;

	assign msum_m1  = msum_q - 13'd1;
	assign mul_a    = cmd.mul_sel_month ? {1'b0, msum_m1[12:2]} : year_q[13:2];
	assign mul_b    = cmd.mul_sel_month ? RECIP_3 : RECIP_25;

	assign fold_k     = prod_q[19:11];
	assign fold_12k   = 13'({fold_k, 3'b000}) + 13'({fold_k, 2'b00});
	assign fold_month = msum_q - fold_12k;
	assign year_sum   = {1'b0, year_q} + 15'(fold_k);
	assign add_year_sum = {1'b0, year_q} + 15'(amt_q);

	assign split_c   = prod_q[21:15];
	assign split_rem = year_q - 14'({split_c, 6'b0}) - 14'({split_c, 5'b0})
		- 14'({split_c, 2'b0});

	// leap from the tracked century and year-in-century
	assign leap = (year_q[1:0] == 2'b00) && ((yrem_q != 7'd0) || (cent_q[1:0] == 2'b00));
	assign mlen = cde_pkg::days_in(month_q, leap);
	assign fits = dsum_q <= 13'(mlen);

	assign held_key  = {year_q, month_q, day_q};
	assign given_key = {iy_q, im_q, id_q};

	assign stat.action   = act_q;
	assign stat.month_ok = cde_pkg::month_in_range(month_q);
	assign stat.day_fits = fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q  <= cde_pkg::YEAR_RESET;
			month_q <= cde_pkg::MONTH_RESET;
			day_q   <= cde_pkg::DAY_RESET;
		end else begin
			if (cmd.apply) begin
				case (act_q)
					cde_pkg::ACT_LOAD: begin
						year_q  <= (iy_q > cde_pkg::YEAR_MAX) ? cde_pkg::YEAR_MAX : iy_q;
						month_q <= im_q;
						day_q   <= id_q;
					end
					cde_pkg::ACT_ADD_YEARS: begin
						year_q <= (add_year_sum > 15'(cde_pkg::YEAR_MAX)) ?
							cde_pkg::YEAR_MAX : add_year_sum[13:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.fold) begin
				if (msum_q > 13'(cde_pkg::MONTH_DEC)) begin
					month_q <= fold_month[3:0];
					year_q  <= (year_sum > 15'(cde_pkg::YEAR_MAX)) ?
						cde_pkg::YEAR_MAX : year_sum[13:0];
				end else begin
					month_q <= msum_q[3:0];
				end
			end
			if (cmd.day_step) begin
				if (fits) begin
					day_q <= dsum_q[4:0];
				end else if (month_q == cde_pkg::MONTH_DEC) begin
					month_q <= 4'd1;
					if (year_q != cde_pkg::YEAR_MAX) begin
						year_q <= year_q + 14'd1;
					end
				end else begin
					month_q <= month_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= action;
			iy_q  <= in_year;
			im_q  <= in_month;
			id_q  <= in_day;
			amt_q <= amount;
			ovf_q <= 1'b0;
			lt_q  <= 1'b0;
			eq_q  <= 1'b0;
			gt_q  <= 1'b0;
		end
		if (cmd.apply) begin
			case (act_q)
				cde_pkg::ACT_LOAD: begin
					ovf_q <= iy_q > cde_pkg::YEAR_MAX;
				end
				cde_pkg::ACT_ADD_DAYS: begin
					dsum_q <= 13'(day_q) + 13'(amt_q);
				end
				cde_pkg::ACT_ADD_MONTHS: begin
					msum_q <= 13'(month_q) + 13'(amt_q);
				end
				cde_pkg::ACT_ADD_YEARS: begin
					ovf_q <= add_year_sum > 15'(cde_pkg::YEAR_MAX);
				end
				cde_pkg::ACT_COMPARE: begin
					lt_q <= held_key < given_key;
					eq_q <= held_key == given_key;
					gt_q <= held_key > given_key;
				end
				default: begin
				end
			endcase
		end
		if (cmd.mul_load) begin
			prod_q <= 23'(mul_a) * 23'(mul_b);
		end
		if (cmd.fold && (msum_q > 13'(cde_pkg::MONTH_DEC))
			&& (year_sum > 15'(cde_pkg::YEAR_MAX))) begin
			ovf_q <= 1'b1;
		end
		if (cmd.split) begin
			cent_q <= split_c;
			yrem_q <= split_rem[6:0];
		end
		if (cmd.day_step && !fits) begin
			dsum_q <= dsum_q - 13'(mlen);
			if (month_q == cde_pkg::MONTH_DEC) begin
				if (year_q == cde_pkg::YEAR_MAX) begin
					ovf_q <= 1'b1;
				end else if (yrem_q == 7'd99) begin
					yrem_q <= 7'd0;
					cent_q <= cent_q + 7'd1;
				end else begin
					yrem_q <= yrem_q + 7'd1;
				end
			end
		end
		if (cmd.out_load) begin
			cur_year      <= year_q;
			cur_month     <= month_q;
			cur_day       <= day_q;
			date_valid    <= cde_pkg::month_in_range(month_q) && (day_q != 5'd0)
				&& (day_q <= mlen);
			is_less       <= lt_q;
			is_equal      <= eq_q;
			is_greater    <= gt_q;
			year_overflow <= ovf_q;
		end
	end

endmodule

FILE: sv/cde_ctrl.sv
// ----------------------------------------------------------------------------
// cde_ctrl
// Controller: sequences one transaction through apply, month fold, leap
// split and the month-by-month day roll, and owns the output valid flag.
// ----------------------------------------------------------------------------
module cde_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  cde_pkg::stat_t stat,
	output cde_pkg::cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE       = 8'b0000_0001,
		S_APPLY      = 8'b0000_0010,
		S_MUL        = 8'b0000_0100,
		S_FOLD       = 8'b0000_1000,
		S_LEAP_MUL   = 8'b0001_0000,
		S_LEAP_SPLIT = 8'b0010_0000,
		S_DAYS       = 8'b0100_0000,
		S_DONE       = 8'b1000_0000
	} state_t;

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_nx = (stat.action == cde_pkg::ACT_ADD_MONTHS) ? S_MUL : S_LEAP_MUL;
			end
			S_MUL: begin
				cmd.mul_load = 1'b1;
				cmd.mul_sel_month = 1'b1;
				state_nx = S_FOLD;
			end
			S_FOLD: begin
				cmd.fold = 1'b1;
				state_nx = S_LEAP_MUL;
			end
			S_LEAP_MUL: begin
				cmd.mul_load = 1'b1;
				state_nx = S_LEAP_SPLIT;
			end
			S_LEAP_SPLIT: begin
				cmd.split = 1'b1;
				state_nx = ((stat.action == cde_pkg::ACT_ADD_DAYS) && stat.month_ok) ?
					S_DAYS : S_DONE;
			end
			S_DAYS: begin
				cmd.day_step = 1'b1;
				if (stat.day_fits) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/calendar_date_engine.sv
// ----------------------------------------------------------------------------
// calendar_date_engine
// Holds one Gregorian date and applies load, add-days, add-months, add-years
// or compare per transaction, returning the held date and flags.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  input   | in_valid / in_ready  | action, in_year, in_month, in_day, amount
//  output  | out_valid / out_ready| cur_year, cur_month, cur_day, date_valid,
//          |                      | is_less, is_equal, is_greater, year_overflow
//
//  a transaction steps through apply, leap multiply and leap split before the
//  result register loads (add-months adds a multiply and a fold step first).
//  add-days then rolls the held date one month per cycle until the day fits.
//  one transaction in flight; a new one is taken while the result waits.
//  reset brings the held date to 1970-01-01 and empties the output register.
//  a result that is not taken holds the engine in its final state.
// ----------------------------------------------------------------------------
module calendar_date_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [cde_pkg::ACTION_W-1:0] action,
	input  logic [cde_pkg::YEAR_W-1:0]   in_year,
	input  logic [cde_pkg::MONTH_W-1:0]  in_month,
	input  logic [cde_pkg::DAY_W-1:0]    in_day,
	input  logic [cde_pkg::AMT_W-1:0]    amount,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [cde_pkg::YEAR_W-1:0]   cur_year,
	output logic [cde_pkg::MONTH_W-1:0]  cur_month,
	output logic [cde_pkg::DAY_W-1:0]    cur_day,
	output logic                         date_valid,
	output logic                         is_less,
	output logic                         is_equal,
	output logic                         is_greater,
	output logic                         year_overflow
);

	cde_pkg::cmd_t  cmd;
	cde_pkg::stat_t stat;

	cde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cde_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.action        (action),
		.in_year       (in_year),
		.in_month      (in_month),
		.in_day        (in_day),
		.amount        (amount),
		.cur_year      (cur_year),
		.cur_month     (cur_month),
		.cur_day       (cur_day),
		.date_valid    (date_valid),
		.is_less       (is_less),
		.is_equal      (is_equal),
		.is_greater    (is_greater),
		.year_overflow (year_overflow)
	);

`ifndef SYNTHESIS
	// at most one compare flag per result
	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({is_less, is_equal, is_greater}))
		else $error("more than one compare flag set");

	// saturation leaves the year pinned at its ceiling
	a_ovf_year: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && year_overflow) |-> (cur_year == cde_pkg::YEAR_MAX))
		else $error("overflow reported below the year ceiling");

	// held year never passes the ceiling
	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cur_year <= cde_pkg::YEAR_MAX))
		else $error("held year above ceiling");

	// a valid date has a real month and a non-zero day
	a_valid_date: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && date_valid) |->
		((cur_month != 4'd0) && (cur_month <= cde_pkg::MONTH_DEC) && (cur_day != 5'd0)))
		else $error("date flagged valid with bad month or day");
`endif

endmodule

FILE: test/calendar_date_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_engine_tb
// Self-checking bench for the date engine. A short run of corner dates comes
// first, then random action streams under four flow-control regimes. Every
// result is compared field by field with a date model kept in a scoreboard.
// ----------------------------------------------------------------------------
module calendar_date_engine_tb;
	import cde_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;
	localparam int unsigned RANDOM_ITEMS = 1640;
	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned TAIL_CYCLES  = 200;
	localparam int unsigned SEND_IDLE [4]   = '{0, 65, 0, 31};
	localparam int unsigned READY_STALL [4] = '{0, 0, 65, 31};

	typedef struct {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic               valid;
		logic               less;
		logic               equal;
		logic               greater;
		logic               overflow;
	} date_result_t;

	class date_checker;
		int unsigned  year_now;
		int unsigned  month_now;
		int unsigned  day_now;
		date_result_t expected_dates[$];
		int unsigned  failures;

		function new();
			year_now  = 32'(YEAR_RESET);
			month_now = 32'(MONTH_RESET);
			day_now   = 32'(DAY_RESET);
			failures  = 0;
		endfunction

		function bit leap_year(int unsigned y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		function int unsigned month_length(int unsigned m, int unsigned y);
			int unsigned len;
			len = 32'(MONTH_LEN[(m >= 1 && m <= 12) ? m - 1 : 0]);
			if (m == MONTH_FEB && leap_year(y)) begin
				len++;
			end
			return len;
		endfunction

		// saturating year increment, reports whether it clipped
		function bit bump_year(int unsigned k);
			if (year_now + k > 32'(YEAR_MAX)) begin
				year_now = 32'(YEAR_MAX);
				return 1'b1;
			end
			year_now = year_now + k;
			return 1'b0;
		endfunction

		function void note_input(logic [ACTION_W-1:0] act, logic [YEAR_W-1:0] y,
			logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d, logic [AMT_W-1:0] amt);
			date_result_t r;
			int unsigned  sum;
			int unsigned  k;
			logic [22:0]  held_key;
			logic [22:0]  given_key;
			r.less     = 1'b0;
			r.equal    = 1'b0;
			r.greater  = 1'b0;
			r.overflow = 1'b0;
			case (act)
				ACT_LOAD: begin
					if (y > YEAR_MAX) begin
						year_now   = 32'(YEAR_MAX);
						r.overflow = 1'b1;
					end else begin
						year_now = 32'(y);
					end
					month_now = 32'(m);
					day_now   = 32'(d);
				end
				ACT_ADD_DAYS: begin
					// nothing happens while the held month is out of range
					if (month_now >= 1 && month_now <= 12) begin
						sum = day_now + 32'(amt);
						while (sum > month_length(month_now, year_now)) begin
							sum = sum - month_length(month_now, year_now);
							month_now++;
							if (month_now > 12) begin
								month_now = 1;
								r.overflow |= bump_year(1);
							end
						end
						day_now = sum;
					end
				end
				ACT_ADD_MONTHS: begin
					sum = month_now + 32'(amt);
					if (sum > 12) begin
						k   = (sum - 1) / 12;
						sum = sum - 12 * k;
						r.overflow |= bump_year(k);
					end
					month_now = sum;
				end
				ACT_ADD_YEARS: begin
					r.overflow = bump_year(32'(amt));
				end
				ACT_COMPARE: begin
					held_key  = {year_now[YEAR_W-1:0], month_now[MONTH_W-1:0],
						day_now[DAY_W-1:0]};
					given_key = {y, m, d};
					r.less    = held_key < given_key;
					r.equal   = held_key == given_key;
					r.greater = held_key > given_key;
				end
				default: begin
				end
			endcase
			r.year  = year_now[YEAR_W-1:0];
			r.month = month_now[MONTH_W-1:0];
			r.day   = day_now[DAY_W-1:0];
			r.valid = month_now >= 1 && month_now <= 12 && day_now >= 1 &&
				day_now <= month_length(month_now, year_now);
			expected_dates = {expected_dates, r};
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] seen);
			if (seen !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
					want, seen);
				failures++;
			end
		endfunction

		function void check_result(date_result_t got);
			date_result_t want;
			if (expected_dates.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, actual %0d-%0d-%0d",
					$time, got.year, got.month, got.day);
				failures++;
			end else begin
				want = expected_dates.pop_front();
				check_field("cur_year", 32'(want.year), 32'(got.year));
				check_field("cur_month", 32'(want.month), 32'(got.month));
				check_field("cur_day", 32'(want.day), 32'(got.day));
				check_field("date_valid", 32'(want.valid), 32'(got.valid));
				check_field("is_less", 32'(want.less), 32'(got.less));
				check_field("is_equal", 32'(want.equal), 32'(got.equal));
				check_field("is_greater", 32'(want.greater), 32'(got.greater));
				check_field("year_overflow", 32'(want.overflow), 32'(got.overflow));
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [ACTION_W-1:0] action;
	logic [YEAR_W-1:0]   in_year;
	logic [MONTH_W-1:0]  in_month;
	logic [DAY_W-1:0]    in_day;
	logic [AMT_W-1:0]    amount;
	logic                out_valid;
	logic                out_ready;
	logic [YEAR_W-1:0]   cur_year;
	logic [MONTH_W-1:0]  cur_month;
	logic [DAY_W-1:0]    cur_day;
	logic                date_valid;
	logic                is_less;
	logic                is_equal;
	logic                is_greater;
	logic                year_overflow;

	int unsigned send_idle_pct   = 0;
	int unsigned ready_stall_pct = 0;
	date_checker tracker = new();

	calendar_date_engine uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// present one transaction, hold it until taken, then maybe go quiet
	task automatic send_item(logic [ACTION_W-1:0] act, logic [YEAR_W-1:0] y,
		logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d, logic [AMT_W-1:0] amt);
		in_valid <= 1'b1;
		action   <= act;
		in_year  <= y;
		in_month <= m;
		in_day   <= d;
		amount   <= amt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_input(act, y, m, d, amt);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_dates.size() != 0) @(posedge clk);
	endtask

	// result side
	initial begin
		date_result_t got;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.year     = cur_year;
				got.month    = cur_month;
				got.day      = cur_day;
				got.valid    = date_valid;
				got.less     = is_less;
				got.equal    = is_equal;
				got.greater  = is_greater;
				got.overflow = year_overflow;
				tracker.check_result(got);
			end
			out_ready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	// watchdog on cycles with no transaction on either side
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		int unsigned         pick;
		int unsigned         sel;
		logic [ACTION_W-1:0] act;
		logic [YEAR_W-1:0]   y;
		logic [MONTH_W-1:0]  m;
		logic [DAY_W-1:0]    d;
		logic [AMT_W-1:0]    amt;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		action   <= ACT_LOAD;
		in_year  <= '0;
		in_month <= '0;
		in_day   <= '0;
		amount   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner dates
		send_item(ACT_COMPARE, 14'd1970, 4'd1, 5'd1, '0);
		send_item(ACT_LOAD, '1, '1, '1, '0);
		send_item(ACT_ADD_DAYS, '0, '0, '0, 12'd5);
		send_item(ACT_ADD_MONTHS, '0, '0, '0, '0);
		send_item(ACT_LOAD, '0, '0, '0, '0);
		send_item(ACT_ADD_DAYS, '0, '0, '0, 12'd3);
		send_item(ACT_ADD_MONTHS, '0, '0, '0, '0);
		send_item(ACT_ADD_MONTHS, '0, '0, '0, 12'd5);
		send_item(ACT_LOAD, 14'd2000, 4'd2, 5'd28, '0);
		send_item(ACT_ADD_DAYS, '0, '0, '0, 12'd1);
		send_item(ACT_ADD_DAYS, '0, '0, '0, 12'd1);
		send_item(ACT_LOAD, 14'd1900, 4'd2, 5'd28, '0);
		send_item(ACT_ADD_DAYS, '0, '0, '0, 12'd1);
		send_item(ACT_LOAD, 14'd2024, 4'd2, 5'd0, '0);
		send_item(ACT_ADD_DAYS, '0, '0, '0, '0);
		send_item(ACT_ADD_DAYS, '0, '0, '0, 12'd29);
		send_item(ACT_LOAD, 14'd2023, 4'd4, 5'd31, '0);
		send_item(ACT_ADD_DAYS, '0, '0, '0, '0);
		send_item(ACT_LOAD, 14'd9998, 4'd12, 5'd31, '0);
		send_item(ACT_ADD_DAYS, '0, '0, '0, '1);
		send_item(ACT_ADD_YEARS, '0, '0, '0, '1);
		send_item(ACT_LOAD, 14'd2020, 4'd1, 5'd31, '0);
		send_item(ACT_ADD_MONTHS, '0, '0, '0, 12'd1);
		send_item(ACT_ADD_MONTHS, '0, '0, '0, '1);
		send_item(ACT_COMPARE, '1, '0, '0, '0);
		send_item(ACT_COMPARE, '0, '1, '1, '0);
		send_item(ACT_SPARE_LAST, '1, '1, '1, '1);
		drain_results();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct   = SEND_IDLE[p];
			ready_stall_pct = READY_STALL[p];
			for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
				pick = $urandom_range(99);
				sel  = $urandom_range(9);
				y    = 14'($urandom);
				m    = 4'($urandom);
				d    = 5'($urandom);
				amt  = 12'($urandom);
				if (pick < 15) begin
					act = ACT_LOAD;
					// mostly sensible dates, the rest raw field values
					if ($urandom_range(3) != 0) begin
						y = (sel == 0) ? 14'($urandom_range(9999, 9985)) :
							14'($urandom_range(2500, 1580));
						m = 4'($urandom_range(12, 1));
						d = 5'($urandom_range(tracker.month_length(32'(m), 32'(y)), 1));
					end
				end else if (pick < 50) begin
					act = ACT_ADD_DAYS;
					if (sel < 6) begin
						amt = 12'($urandom_range(40));
					end else if (sel < 9) begin
						amt = 12'($urandom_range(400));
					end
				end else if (pick < 63) begin
					act = ACT_ADD_MONTHS;
					if (sel < 9) begin
						amt = 12'($urandom_range(30));
					end
				end else if (pick < 71) begin
					act = ACT_ADD_YEARS;
					if (sel < 9 || $urandom_range(1) == 0) begin
						amt = 12'($urandom_range(10));
					end
				end else if (pick < 95) begin
					act = ACT_COMPARE;
					// near the held date so every ordering turns up
					if ($urandom_range(3) != 0) begin
						y = 14'(tracker.year_now);
						m = 4'(tracker.month_now);
						d = 5'(tracker.day_now);
						sel = $urandom_range(3);
						if (sel == 1) begin
							y = y + 14'($urandom_range(2)) - 14'd1;
						end else if (sel == 2) begin
							m = m + 4'($urandom_range(2)) - 4'd1;
						end else if (sel == 3) begin
							d = d + 5'($urandom_range(2)) - 5'd1;
						end
					end
				end else begin
					act = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
				end
				send_item(act, y, m, d, amt);
				if ($urandom_range(199) == 0) begin
					drain_results();
				end
			end
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: calendar_date_engine.f
sv/cde_pkg.sv
sv/cde_dp.sv
sv/cde_ctrl.sv
sv/calendar_date_engine.sv
test/calendar_date_engine_tb.sv
